// ----- hw/rtl/cartesian_to_spherical_macros.svh -----
// Assertion macros for the cartesian_to_spherical block
`ifndef CARTESIAN_TO_SPHERICAL_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_MACROS_SVH

// Same-cycle implication, checked out of reset
`define C2S_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("c2s check failed");

// Next-cycle implication, checked out of reset
`define C2S_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("c2s check failed");

`endif

// ----- hw/rtl/c2s_pkg.sv -----
`timescale 1ns / 1ps
package c2s_pkg;

    // Input transaction: Q16.16 point
    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } in_t;

    // Output transaction
    typedef struct packed {
        logic [31:0] radius;
        logic [29:0] polar_angle;
        logic [30:0] azimuth;
        logic        zero_vector;
    } out_t;

    // Micro-rotation count, capped at 62
    localparam int CORDIC_ITERATIONS = 30;
    localparam int CORDIC_N = (CORDIC_ITERATIONS > 62) ? 62 : CORDIC_ITERATIONS;

    // Square root: one result bit per stage plus a rounding stage
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_LAT   = SQRT_STEPS + 1;

    // CORDIC vector width (16 guard bits) and angle width (Q2.30 plus headroom)
    localparam int CW = 52;
    localparam int AW = 36;

    // Front stages (input, squares, two adds), square roots, prep, CORDIC, three finishing stages
    localparam int NSTAGE = 4 + SQRT_LAT + 1 + CORDIC_N + 3;

    localparam logic signed [AW-1:0] PI_Q30         = 36'sd3373259426;
    localparam logic signed [AW-1:0] HALF_PI_Q30    = 36'sd1686629713;
    localparam logic signed [AW-1:0] THR_HALF_PI_Q30 = 36'sd5059889139;
    localparam logic signed [AW-1:0] TWO_PI_Q30     = 36'sd6746518852;
    localparam logic [30:0]          TWO_PI_Q28     = 31'd1686629713;

    // Side information carried alongside the CORDIC lanes
    typedef struct packed {
        logic        zero;
        logic        xy0;
        logic        z0;
        logic        zpos;
        logic        y0;
        logic        x0;
        logic        xneg;
        logic        ypos;
        logic [31:0] rho;
    } side_t;

    // atan(2^-i) in Q2.30, first ten entries
    localparam logic [31:0] ATAN_HEAD [0:9] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
        32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149
    };

    function automatic logic signed [AW-1:0] step_angle(input int i);
        logic signed [AW-1:0] r;
        r = '0;
        if (i < 10)
            r = AW'(ATAN_HEAD[i]);
        else if (i <= 30)
            r = AW'(64'd1 << (30 - i));
        return r;
    endfunction

endpackage

// ----- hw/rtl/cartesian_to_spherical.sv -----
`timescale 1ns / 1ps
// Cartesian to spherical conversion, one Q16.16 point per transaction.
// Input channel in_valid/in_ready/in_data carries x, y, z; output channel
// out_valid/out_ready/out_data carries radius (Q16.16), polar angle and
// azimuth (radians * 2^28) and a zero-vector flag.
// Stages: four front stages (input, squares, two adds), 33 square-root
// stages, one prep stage, one stage per CORDIC micro-rotation and three
// finishing stages.
// Throughput: one transaction per cycle unless the output stalls; every
// stage is a register with a valid bit, so bubbles simply travel through.
// Stall: when the output holds a transaction that is not taken, the whole
// pipeline freezes and in_ready drops; nothing is lost or repeated.
// Reset: rst_n clears all valid bits; the block is ready right away.
// The azimuth runs in CORDIC lanes parallel to the polar angle, both
// starting after the square roots.
module cartesian_to_spherical (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  c2s_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output c2s_pkg::out_t  out_data
);
    import c2s_pkg::*;

    logic              en;
    logic [NSTAGE-1:0] vld_reg;
    logic [NSTAGE-1:0] vld_next;

    // Global advance: move unless the output holds an untaken result
    assign en       = !vld_reg[NSTAGE-1] || out_ready;
    assign in_ready = en;

    always_comb
    begin
        vld_next = en ? {vld_reg[NSTAGE-2:0], in_valid} : vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Front: input register, squares, sums
    in_t         p1_reg, p2_reg, p3_reg, p4_reg;
    logic [63:0] xx_reg, yy_reg, zz_reg, zz3_reg, sxy3_reg, sxy4_reg, sxyz_reg;
    logic signed [63:0] xx_p, yy_p, zz_p;

    assign xx_p = p1_reg.coord_x * p1_reg.coord_x;
    assign yy_p = p1_reg.coord_y * p1_reg.coord_y;
    assign zz_p = p1_reg.coord_z * p1_reg.coord_z;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= in_data;
            p2_reg   <= p1_reg;
            xx_reg   <= xx_p;
            yy_reg   <= yy_p;
            zz_reg   <= zz_p;
            p3_reg   <= p2_reg;
            sxy3_reg <= xx_reg + yy_reg;
            zz3_reg  <= zz_reg;
            p4_reg   <= p3_reg;
            sxy4_reg <= sxy3_reg;
            sxyz_reg <= sxy3_reg + zz3_reg;
        end
    end

    // Square roots: full magnitude and xy magnitude
    logic [31:0] rho_root, rxy_root;

    c2s_isqrt u_sqrt_rho (
        .clk      (clk),
        .en       (en),
        .radicand (sxyz_reg),
        .root     (rho_root)
    );

    c2s_isqrt u_sqrt_rxy (
        .clk      (clk),
        .en       (en),
        .radicand (sxy4_reg),
        .root     (rxy_root)
    );

    // Point delayed to line up with the roots
    in_t dly_reg [0:SQRT_LAT-1];

    genvar g;
    generate
        for (g = 0; g < SQRT_LAT; g++) begin : g_dly
            always_ff @(posedge clk)
            begin
                if (en)
                    dly_reg[g] <= (g == 0) ? p4_reg : dly_reg[(g == 0) ? 0 : g - 1];
            end
        end
    endgenerate

    // Prep: CORDIC operands and case flags
    in_t                pt;
    logic signed [32:0] xs, ys, zs;
    logic signed [32:0] ta_reg, tb_reg, pa_reg, pb_reg;
    side_t              side_next;
    side_t              side_reg [0:CORDIC_N];

    assign pt = dly_reg[SQRT_LAT-1];
    assign xs = 33'(pt.coord_x);
    assign ys = 33'(pt.coord_y);
    assign zs = 33'(pt.coord_z);

    always_comb
    begin
        side_next.zero = (pt.coord_x == '0) && (pt.coord_y == '0) && (pt.coord_z == '0);
        side_next.xy0  = (pt.coord_x == '0) && (pt.coord_y == '0);
        side_next.z0   = (pt.coord_z == '0);
        side_next.zpos = !pt.coord_z[31] && (pt.coord_z != '0);
        side_next.y0   = (pt.coord_y == '0);
        side_next.x0   = (pt.coord_x == '0);
        side_next.xneg = pt.coord_x[31];
        side_next.ypos = !pt.coord_y[31] && (pt.coord_y != '0);
        side_next.rho  = rho_root;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg      <= side_next.zpos ? zs : -zs;
            tb_reg      <= {1'b0, rxy_root};
            pa_reg      <= xs[32] ? -xs : xs;
            pb_reg      <= xs[32] ? -ys : ys;
            side_reg[0] <= side_next;
        end
    end

    generate
        for (g = 1; g <= CORDIC_N; g++) begin : g_side
            always_ff @(posedge clk)
            begin
                if (en)
                    side_reg[g] <= side_reg[g-1];
            end
        end
    endgenerate

    // CORDIC lanes
    logic signed [AW-1:0] acc_t, acc_p;

    c2s_cordic u_cordic_theta (
        .clk   (clk),
        .en    (en),
        .a     (ta_reg),
        .b     (tb_reg),
        .angle (acc_t)
    );

    c2s_cordic u_cordic_phi (
        .clk   (clk),
        .en    (en),
        .a     (pa_reg),
        .b     (pb_reg),
        .angle (acc_p)
    );

    // Finish 1: select special cases and quadrant
    side_t                sd, f1_side_reg, f2_side_reg;
    logic signed [AW-1:0] th1_next, ph1_next, th1_reg, ph1_reg;

    assign sd = side_reg[CORDIC_N];

    always_comb
    begin
        if (sd.xy0)
            th1_next = sd.zpos ? '0 : PI_Q30;
        else if (sd.z0)
            th1_next = HALF_PI_Q30;
        else if (sd.zpos)
            th1_next = acc_t;
        else
            th1_next = PI_Q30 - acc_t;

        if (sd.y0)
            ph1_next = sd.xneg ? PI_Q30 : '0;
        else if (sd.x0)
            ph1_next = sd.ypos ? HALF_PI_Q30 : THR_HALF_PI_Q30;
        else if (!sd.xneg)
            ph1_next = acc_p;
        else
            ph1_next = PI_Q30 + acc_p;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th1_reg     <= th1_next;
            ph1_reg     <= ph1_next;
            f1_side_reg <= sd;
        end
    end

    // Finish 2: clamp theta, wrap phi into [0, 2pi)
    logic signed [AW-1:0] th2_next, ph2_next, th2_reg, ph2_reg, ph_up, ph_dn;

    assign ph_up = ph1_reg + TWO_PI_Q30;
    assign ph_dn = ph1_reg - TWO_PI_Q30;

    always_comb
    begin
        if (th1_reg[AW-1])
            th2_next = '0;
        else if (th1_reg > PI_Q30)
            th2_next = PI_Q30;
        else
            th2_next = th1_reg;

        if (ph1_reg[AW-1])
            ph2_next = ph_up[AW-1] ? '0 : ph_up;
        else if (ph1_reg >= TWO_PI_Q30)
            ph2_next = ph_dn;
        else
            ph2_next = ph1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            th2_reg     <= th2_next;
            ph2_reg     <= ph2_next;
            f2_side_reg <= f1_side_reg;
        end
    end

    // Finish 3: round to radians * 2^28, output register
    logic [AW-1:0] th_rnd, ph_rnd;
    logic [30:0]   ph_q;
    out_t          out_next, out_reg;

    assign th_rnd = (th2_reg + AW'(2)) >>> 2;
    assign ph_rnd = (ph2_reg + AW'(2)) >>> 2;
    assign ph_q   = (ph_rnd[30:0] >= TWO_PI_Q28) ? ph_rnd[30:0] - TWO_PI_Q28 : ph_rnd[30:0];

    always_comb
    begin
        out_next.radius      = f2_side_reg.rho;
        out_next.zero_vector = f2_side_reg.zero;
        out_next.polar_angle = f2_side_reg.zero ? '0 : th_rnd[29:0];
        out_next.azimuth     = f2_side_reg.zero ? '0 : ph_q;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    assign out_valid = vld_reg[NSTAGE-1];
    assign out_data  = out_reg;

endmodule

// ----- hw/rtl/c2s_isqrt.sv -----
`timescale 1ns / 1ps
// Pipelined integer square root, rounded to nearest, one root bit per stage
module c2s_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);
    import c2s_pkg::*;

    logic [63:0] rem_reg  [0:SQRT_STEPS-1];
    logic [63:0] root_reg [0:SQRT_STEPS-1];
    logic [31:0] out_reg;

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++) begin : g_step
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            logic [63:0] rem_in;
            logic [63:0] root_in;
            logic [63:0] trial;
            logic [63:0] rem_next;
            logic [63:0] root_next;

            if (k == 0) begin : g_first
                assign rem_in  = radicand;
                assign root_in = '0;
            end
            else begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            // Restoring step: subtract when the trial value fits
            always_comb
            begin
                trial = root_in + BIT;
                if (rem_in >= trial)
                begin
                    rem_next  = rem_in - trial;
                    root_next = (root_in >> 1) + BIT;
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end
        end
    endgenerate

    // Round to nearest: bump when remainder exceeds root
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= root_reg[SQRT_STEPS-1][31:0] +
                       32'(rem_reg[SQRT_STEPS-1] > root_reg[SQRT_STEPS-1]);
    end

    assign root = out_reg;

endmodule

// ----- hw/rtl/c2s_cordic.sv -----
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC: atan(b/a) in Q2.30 for a > 0, one rotation per stage
module c2s_cordic (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [32:0]            a,
    input  logic signed [32:0]            b,
    output logic signed [c2s_pkg::AW-1:0] angle
);
    import c2s_pkg::*;

    logic signed [CW-1:0] cx_reg  [0:CORDIC_N-1];
    logic signed [CW-1:0] cy_reg  [0:CORDIC_N-1];
    logic signed [AW-1:0] acc_reg [0:CORDIC_N-1];

    genvar k;
    generate
        for (k = 0; k < CORDIC_N; k++) begin : g_rot
            localparam logic signed [AW-1:0] ANG = step_angle(k);
            logic signed [CW-1:0] cx_in, cy_in, dx, dy;
            logic signed [AW-1:0] acc_in;

            if (k == 0) begin : g_first
                // Scale by the guard factor
                assign cx_in  = CW'(a) <<< 16;
                assign cy_in  = CW'(b) <<< 16;
                assign acc_in = '0;
            end
            else begin : g_rest
                assign cx_in  = cx_reg[k-1];
                assign cy_in  = cy_reg[k-1];
                assign acc_in = acc_reg[k-1];
            end

            assign dx = cy_in >>> k;
            assign dy = cx_in >>> k;

            // Rotate toward the x axis
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (!cy_in[CW-1])
                    begin
                        cx_reg[k]  <= cx_in + dx;
                        cy_reg[k]  <= cy_in - dy;
                        acc_reg[k] <= acc_in + ANG;
                    end
                    else
                    begin
                        cx_reg[k]  <= cx_in - dx;
                        cy_reg[k]  <= cy_in + dy;
                        acc_reg[k] <= acc_in - ANG;
                    end
                end
            end
        end
    endgenerate

    assign angle = acc_reg[CORDIC_N-1];

endmodule

// ----- hw/rtl/c2s_checker.sv -----
`timescale 1ns / 1ps
`include "cartesian_to_spherical_macros.svh"
// Port-level checks for cartesian_to_spherical
module c2s_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input c2s_pkg::out_t out_data
);
    import c2s_pkg::*;

    // Held result stays put
    `C2S_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    // Stalled output freezes the pipe, so input is refused
    `C2S_ASSERT_NOW(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
    // Zero vector gives all-zero coordinates
    `C2S_ASSERT_NOW(a_zero_vec, out_valid && out_data.zero_vector,
        out_data.radius == '0 && out_data.polar_angle == '0 && out_data.azimuth == '0)
    // Azimuth wrapped below 2pi
    `C2S_ASSERT_NOW(a_az_range, out_valid, out_data.azimuth < TWO_PI_Q28)
    // Polar angle within [0, pi]
    `C2S_ASSERT_NOW(a_pol_range, out_valid, out_data.polar_angle <= 30'd843314857)

endmodule

bind cartesian_to_spherical c2s_checker u_c2s_checker (.*);
